@@ src/pclm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pclm_pkg: shared types and constants of the pooled cursor list manager
// Sizes, opcode and status codes, request/result items and the command
// and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package pclm_pkg;

  localparam int NODE_COUNT   = 256;
  localparam int LIST_SLOTS   = 16;
  localparam int ITEM_BITS    = 32;
  localparam int USABLE_SLOTS = LIST_SLOTS - 1;
  localparam int LINK_DEPTH   = NODE_COUNT + USABLE_SLOTS;
  localparam int NODE_AW      = $clog2(NODE_COUNT);
  localparam int LINK_AW      = $clog2(LINK_DEPTH);
  localparam int SLOT_AW      = $clog2(LIST_SLOTS);
  localparam int CNT_W        = $clog2(NODE_COUNT + 1);

  typedef enum logic [3:0] {
    OP_CREATE  = 4'd0,
    OP_COUNT   = 4'd1,
    OP_FIRST   = 4'd2,
    OP_LAST    = 4'd3,
    OP_NEXT    = 4'd4,
    OP_PREV    = 4'd5,
    OP_CURR    = 4'd6,
    OP_ADD     = 4'd7,
    OP_INSERT  = 4'd8,
    OP_APPEND  = 4'd9,
    OP_PREPEND = 4'd10,
    OP_REMOVE  = 4'd11,
    OP_CONCAT  = 4'd12,
    OP_FREE    = 4'd13,
    OP_TRIM    = 4'd14
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NO_ITEM  = 2'd2,
    STAT_NOT_USED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    EDGE_NONE   = 2'd0,
    EDGE_BEFORE = 2'd1,
    EDGE_BEYOND = 2'd2
  } edge_e;

  typedef struct packed {
    logic [3:0]           opcode;
    logic [SLOT_AW-1:0]   list_id;
    logic [SLOT_AW-1:0]   other_list;
    logic [ITEM_BITS-1:0] item;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [ITEM_BITS-1:0] item_out;
    logic                 item_valid;
    logic [CNT_W-1:0]     count_out;
    logic [SLOT_AW-1:0]   new_list;
  } res_t;

  // Datapath micro-operations issued by the controller
  typedef enum logic [4:0] {
    U_NOP,
    U_INIT,
    U_ACCEPT,
    U_DECODE,
    U_NAV_RD,
    U_NAV_WB,
    U_REP_RD,
    U_REP_OUT,
    U_NO_ITEM,
    U_FIX_RD,
    U_FIX_WB,
    U_FULL,
    U_ADD_RD1,
    U_ADD_RD2,
    U_ADD_W1,
    U_ADD_W2,
    U_REM_RD,
    U_REM_W1,
    U_REM_W2,
    U_RELEASE,
    U_CAT_REL,
    U_CAT_RD,
    U_CAT_W1,
    U_CAT_W2,
    U_DONE
  } uop_e;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_NAV_RD,
    S_NAV_WB,
    S_REP,
    S_REP_OUT,
    S_ADD_FIX,
    S_FIX_WB,
    S_ADD_CHK,
    S_ADD_RD2,
    S_ADD_W1,
    S_ADD_W2,
    S_REM_CHK,
    S_REM_W1,
    S_REM_W2,
    S_CAT_CHK,
    S_CAT_W1,
    S_CAT_W2,
    S_DONE
  } ctl_state_e;

  typedef struct packed {
    logic [3:0] op;
    logic       op_valid;
    logic       bad;
    logic       same_list;
    logic       cur_head;
    logic       cur_node;
    logic       edge_before;
    logic       edge_beyond;
    logic       pool_full;
    logic       src_empty;
    logic       init_done;
  } dp_flags_t;

endpackage
`default_nettype wire

@@ src/pooled_cursor_list_manager.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pooled_cursor_list_manager: cursor lists over a shared node pool
// Up to fifteen doubly linked lists of item handles in one pool of nodes.
// ----------------------------------------------------------------------------
// After reset the block is busy while it chains the free nodes in the
// link memory. An operation is taken when start_i is high and busy_o is
// low; its result appears on res_o for exactly one cycle with done_o high,
// and there is no way to hold it off, so capture it then. Every step goes
// through the registered link and item memories, one dependent access at
// a time. The cursor move of insert and append and the beyond-end fix-up
// of add lengthen the add-type operations, and free steps through every
// item in the freed list. busy_o drops in the cycle the result is shown,
// so the next operation may start then.
// ----------------------------------------------------------------------------
module pooled_cursor_list_manager (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire pclm_pkg::req_t  req_i,
  output logic                 busy_o,
  output logic                 done_o,
  output pclm_pkg::res_t       res_o
);
  import pclm_pkg::*;

  uop_e      cmd;
  dp_flags_t flags;

  pclm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .flags_i(flags),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  pclm_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .flags_o(flags),
    .res_o  (res_o),
    .done_o (done_o)
  );

endmodule
`default_nettype wire

@@ src/pclm_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pclm_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pclm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ src/pclm_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pclm_ctrl: operation sequencer
// Walks each opcode through its read, update and write-back steps and
// issues one datapath micro-operation per cycle.
// ----------------------------------------------------------------------------
module pclm_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire pclm_pkg::dp_flags_t  flags_i,
  output pclm_pkg::uop_e            cmd_o,
  output logic                      busy_o
);
  import pclm_pkg::*;

  ctl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and command
  always_comb begin
    state_d = state_q;
    cmd_o   = U_NOP;
    busy_o  = 1'b1;
    case (state_q)
      S_INIT: begin
        cmd_o = U_INIT;
        if (flags_i.init_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o   = U_ACCEPT;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o = U_DECODE;
        if (flags_i.op == OP_CREATE || !flags_i.op_valid || flags_i.bad) begin
          state_d = S_DONE;
        end else begin
          case (flags_i.op)
            OP_CURR:   state_d = S_REP;
            OP_FIRST, OP_LAST, OP_NEXT, OP_PREV,
            OP_APPEND, OP_TRIM, OP_FREE: state_d = S_NAV_RD;
            OP_CONCAT: state_d = flags_i.same_list ? S_DONE : S_NAV_RD;
            OP_INSERT: state_d = (flags_i.cur_head && flags_i.edge_before) ?
                                 S_ADD_FIX : S_NAV_RD;
            OP_ADD, OP_PREPEND: state_d = S_ADD_FIX;
            OP_REMOVE: state_d = S_REM_CHK;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_NAV_RD: begin
        cmd_o   = U_NAV_RD;
        state_d = S_NAV_WB;
      end
      S_NAV_WB: begin
        cmd_o = U_NAV_WB;
        case (flags_i.op)
          OP_FIRST, OP_LAST, OP_NEXT, OP_PREV: state_d = S_REP;
          OP_INSERT, OP_APPEND: state_d = S_ADD_FIX;
          OP_TRIM, OP_FREE:     state_d = S_REM_CHK;
          OP_CONCAT:            state_d = S_CAT_CHK;
          default:              state_d = S_DONE;
        endcase
      end
      S_REP: begin
        if (flags_i.cur_node) begin
          cmd_o   = U_REP_RD;
          state_d = S_REP_OUT;
        end else begin
          cmd_o   = U_NO_ITEM;
          state_d = S_DONE;
        end
      end
      S_REP_OUT: begin
        cmd_o   = U_REP_OUT;
        state_d = S_DONE;
      end
      S_ADD_FIX: begin
        if (flags_i.cur_head && flags_i.edge_beyond) begin
          cmd_o   = U_FIX_RD;
          state_d = S_FIX_WB;
        end else begin
          state_d = S_ADD_CHK;
        end
      end
      S_FIX_WB: begin
        cmd_o   = U_FIX_WB;
        state_d = S_ADD_CHK;
      end
      S_ADD_CHK: begin
        if (flags_i.pool_full) begin
          cmd_o   = U_FULL;
          state_d = S_DONE;
        end else begin
          cmd_o   = U_ADD_RD1;
          state_d = S_ADD_RD2;
        end
      end
      S_ADD_RD2: begin
        cmd_o   = U_ADD_RD2;
        state_d = S_ADD_W1;
      end
      S_ADD_W1: begin
        cmd_o   = U_ADD_W1;
        state_d = S_ADD_W2;
      end
      S_ADD_W2: begin
        cmd_o   = U_ADD_W2;
        state_d = S_DONE;
      end
      S_REM_CHK: begin
        if (flags_i.cur_node) begin
          cmd_o   = U_REM_RD;
          state_d = S_REM_W1;
        end else begin
          cmd_o   = (flags_i.op == OP_FREE) ? U_RELEASE : U_NO_ITEM;
          state_d = S_DONE;
        end
      end
      S_REM_W1: begin
        cmd_o   = U_REM_W1;
        state_d = S_REM_W2;
      end
      S_REM_W2: begin
        cmd_o   = U_REM_W2;
        state_d = (flags_i.op == OP_FREE) ? S_REM_CHK : S_DONE;
      end
      S_CAT_CHK: begin
        if (flags_i.src_empty) begin
          cmd_o   = U_CAT_REL;
          state_d = S_DONE;
        end else begin
          cmd_o   = U_CAT_RD;
          state_d = S_CAT_W1;
        end
      end
      S_CAT_W1: begin
        cmd_o   = U_CAT_W1;
        state_d = S_CAT_W2;
      end
      S_CAT_W2: begin
        cmd_o   = U_CAT_W2;
        state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o   = U_DONE;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ src/pclm_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pclm_dp: list manager datapath
// Link and item memories, per-slot list state, free node chain and free
// slot stack, working registers and the result register.
// ----------------------------------------------------------------------------
module pclm_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire pclm_pkg::req_t      req_i,
  input  wire pclm_pkg::uop_e      cmd_i,
  output pclm_pkg::dp_flags_t      flags_o,
  output pclm_pkg::res_t           res_o,
  output logic                     done_o
);
  import pclm_pkg::*;

  // working registers
  logic [3:0]           op_q, op_d;
  logic [SLOT_AW-1:0]   s_q, s_d, s2_q, s2_d;
  logic [ITEM_BITS-1:0] it_q, it_d;
  logic [LINK_AW-1:0]   cur_q, cur_d, t1_q, t1_d, t2_q, t2_d, n_q, n_d;
  edge_e                edge_q, edge_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d, cnt2_q, cnt2_d;
  status_e              status_q, status_d;
  logic [ITEM_BITS-1:0] item_q, item_d;
  logic                 valid_q, valid_d, wb_q, wb_d;
  logic [SLOT_AW-1:0]   new_q, new_d;

  // pool bookkeeping
  logic [SLOT_AW-1:0]   slot_top_q, slot_top_d, slots_used_q, slots_used_d;
  logic [LINK_AW-1:0]   node_top_q, node_top_d;
  logic [CNT_W-1:0]     nodes_used_q, nodes_used_d;
  logic [NODE_AW-1:0]   init_q, init_d;

  // per-slot list state
  logic [LINK_AW-1:0]   cursor_q    [LIST_SLOTS];
  edge_e                edge_mark_q [LIST_SLOTS];
  logic [CNT_W-1:0]     items_q     [LIST_SLOTS];
  logic [SLOT_AW-1:0]   free_next_q [LIST_SLOTS];
  logic [LIST_SLOTS-1:0] in_use_q;

  res_t res_q;
  logic done_q;

  // memory ports
  logic                 nx_we, pv_we, it_we;
  logic [LINK_AW-1:0]   nx_waddr, nx_wdata, nx_raddr, nx_rdata;
  logic [LINK_AW-1:0]   pv_waddr, pv_wdata, pv_raddr, pv_rdata;
  logic [NODE_AW-1:0]   it_waddr, it_raddr;
  logic [ITEM_BITS-1:0] it_rdata;

  logic [LINK_AW-1:0]   h_w, h2_w, hc_w, n_w, nav_w;
  logic [SLOT_AW-1:0]   rs_w, rel_w;
  logic                 op_valid_w, bad_w, create_ok_w, rel_en_w, create_en_w;

  pclm_ram #(.WIDTH(LINK_AW), .DEPTH(LINK_DEPTH)) u_next_ram (
    .clk_i  (clk_i),
    .we_i   (nx_we),
    .waddr_i(nx_waddr),
    .wdata_i(nx_wdata),
    .raddr_i(nx_raddr),
    .rdata_o(nx_rdata)
  );

  pclm_ram #(.WIDTH(LINK_AW), .DEPTH(LINK_DEPTH)) u_prev_ram (
    .clk_i  (clk_i),
    .we_i   (pv_we),
    .waddr_i(pv_waddr),
    .wdata_i(pv_wdata),
    .raddr_i(pv_raddr),
    .rdata_o(pv_rdata)
  );

  pclm_ram #(.WIDTH(ITEM_BITS), .DEPTH(NODE_COUNT)) u_item_ram (
    .clk_i  (clk_i),
    .we_i   (it_we),
    .waddr_i(it_waddr),
    .wdata_i(it_q),
    .raddr_i(it_raddr),
    .rdata_o(it_rdata)
  );

  // head nodes, clamped free node and status checks
  assign h_w         = LINK_AW'(NODE_COUNT) + LINK_AW'(s_q);
  assign h2_w        = LINK_AW'(NODE_COUNT) + LINK_AW'(s2_q);
  assign hc_w        = LINK_AW'(NODE_COUNT) + LINK_AW'(slot_top_q);
  assign n_w         = (node_top_q >= LINK_AW'(NODE_COUNT)) ? '0 : node_top_q;
  assign rs_w        = (cmd_i == U_ACCEPT) ? req_i.list_id : s2_q;
  assign op_valid_w  = (op_q <= OP_TRIM);
  assign bad_w       = !in_use_q[s_q] || (op_q == OP_CONCAT && !in_use_q[s2_q]);
  assign create_ok_w = (slots_used_q < SLOT_AW'(USABLE_SLOTS)) &&
                       (slot_top_q < SLOT_AW'(USABLE_SLOTS));
  assign create_en_w = (cmd_i == U_DECODE) && (op_q == OP_CREATE) && create_ok_w;
  assign rel_en_w    = (cmd_i == U_RELEASE) || (cmd_i == U_CAT_REL) ||
                       (cmd_i == U_CAT_W2);
  assign rel_w       = (cmd_i == U_RELEASE) ? s_q : s2_q;
  assign nav_w       = (op_q == OP_FIRST || op_q == OP_NEXT || op_q == OP_FREE) ?
                       nx_rdata : pv_rdata;

  // status to the controller
  always_comb begin
    flags_o.op          = op_q;
    flags_o.op_valid    = op_valid_w;
    flags_o.bad         = bad_w;
    flags_o.same_list   = (s_q == s2_q);
    flags_o.cur_head    = (cur_q == h_w);
    flags_o.cur_node    = (cur_q < LINK_AW'(NODE_COUNT));
    flags_o.edge_before = (edge_q == EDGE_BEFORE);
    flags_o.edge_beyond = (edge_q == EDGE_BEYOND);
    flags_o.pool_full   = (nodes_used_q >= CNT_W'(NODE_COUNT));
    flags_o.src_empty   = (cnt2_q == '0);
    flags_o.init_done   = (init_q == NODE_AW'(NODE_COUNT - 1));
  end

  // micro-operation decode
  always_comb begin
    op_d = op_q; s_d = s_q; s2_d = s2_q; it_d = it_q;
    cur_d = cur_q; t1_d = t1_q; t2_d = t2_q; n_d = n_q;
    edge_d = edge_q; cnt_d = cnt_q; cnt2_d = cnt2_q;
    status_d = status_q; item_d = item_q; valid_d = valid_q;
    wb_d = wb_q; new_d = new_q;
    slot_top_d = slot_top_q; slots_used_d = slots_used_q;
    node_top_d = node_top_q; nodes_used_d = nodes_used_q; init_d = init_q;
    nx_we = 1'b0; nx_waddr = '0; nx_wdata = '0; nx_raddr = '0;
    pv_we = 1'b0; pv_waddr = '0; pv_wdata = '0; pv_raddr = '0;
    it_we = 1'b0; it_waddr = '0; it_raddr = '0;
    case (cmd_i)
      U_INIT: begin
        nx_we    = 1'b1;
        nx_waddr = LINK_AW'(init_q);
        nx_wdata = (init_q == NODE_AW'(NODE_COUNT - 1)) ? '0 :
                   LINK_AW'(init_q) + LINK_AW'(1);
        init_d   = init_q + NODE_AW'(1);
      end
      U_ACCEPT: begin
        op_d     = req_i.opcode;
        s_d      = req_i.list_id;
        s2_d     = req_i.other_list;
        it_d     = req_i.item;
        cur_d    = cursor_q[rs_w];
        edge_d   = edge_mark_q[rs_w];
        cnt_d    = items_q[rs_w];
        status_d = STAT_OK;
        item_d   = '0;
        valid_d  = 1'b0;
        new_d    = '0;
      end
      U_DECODE: begin
        cnt2_d = items_q[rs_w];
        wb_d   = op_valid_w && (op_q != OP_CREATE) && (op_q != OP_FREE) && !bad_w;
        if (op_q == OP_CREATE) begin
          if (create_ok_w) begin
            nx_we        = 1'b1;
            nx_waddr     = hc_w;
            nx_wdata     = hc_w;
            pv_we        = 1'b1;
            pv_waddr     = hc_w;
            pv_wdata     = hc_w;
            new_d        = slot_top_q;
            slot_top_d   = free_next_q[slot_top_q];
            slots_used_d = slots_used_q + SLOT_AW'(1);
          end else begin
            status_d = STAT_FULL;
          end
        end else if (op_valid_w) begin
          if (bad_w) begin
            status_d = STAT_NOT_USED;
          end else if (op_q == OP_PREPEND) begin
            cur_d  = h_w;
            edge_d = EDGE_NONE;
          end
        end
      end
      U_NAV_RD: begin
        nx_raddr = (op_q == OP_NEXT) ? cur_q : h_w;
        pv_raddr = (op_q == OP_PREV || op_q == OP_INSERT) ? cur_q : h_w;
      end
      U_NAV_WB: begin
        cur_d = nav_w;
        case (op_q)
          OP_NEXT: begin
            if (nav_w == h_w) edge_d = EDGE_BEYOND;
          end
          OP_PREV, OP_INSERT: begin
            if (nav_w == h_w) edge_d = EDGE_BEFORE;
          end
          default: edge_d = EDGE_NONE;
        endcase
      end
      U_REP_RD: begin
        it_raddr = cur_q[NODE_AW-1:0];
      end
      U_REP_OUT: begin
        item_d  = it_rdata;
        valid_d = 1'b1;
      end
      U_NO_ITEM: begin
        status_d = STAT_NO_ITEM;
      end
      U_FIX_RD: begin
        pv_raddr = h_w;
      end
      U_FIX_WB: begin
        cur_d  = pv_rdata;
        edge_d = EDGE_NONE;
      end
      U_FULL: begin
        status_d = STAT_FULL;
      end
      U_ADD_RD1: begin
        nx_raddr = n_w;
        n_d      = n_w;
      end
      U_ADD_RD2: begin
        node_top_d = nx_rdata;
        nx_raddr   = cur_q;
      end
      U_ADD_W1: begin
        t1_d     = nx_rdata;
        it_we    = 1'b1;
        it_waddr = n_q[NODE_AW-1:0];
        nx_we    = 1'b1;
        nx_waddr = n_q;
        nx_wdata = nx_rdata;
        pv_we    = 1'b1;
        pv_waddr = n_q;
        pv_wdata = cur_q;
      end
      U_ADD_W2: begin
        pv_we        = 1'b1;
        pv_waddr     = t1_q;
        pv_wdata     = n_q;
        nx_we        = 1'b1;
        nx_waddr     = cur_q;
        nx_wdata     = n_q;
        cur_d        = n_q;
        cnt_d        = cnt_q + CNT_W'(1);
        nodes_used_d = nodes_used_q + CNT_W'(1);
      end
      U_REM_RD: begin
        nx_raddr = cur_q;
        pv_raddr = cur_q;
        it_raddr = cur_q[NODE_AW-1:0];
      end
      U_REM_W1: begin
        t1_d       = pv_rdata;
        t2_d       = nx_rdata;
        nx_we      = 1'b1;
        nx_waddr   = cur_q;
        nx_wdata   = node_top_q;
        node_top_d = cur_q;
        pv_we      = 1'b1;
        pv_waddr   = nx_rdata;
        pv_wdata   = pv_rdata;
        if (op_q != OP_FREE) begin
          item_d  = it_rdata;
          valid_d = 1'b1;
        end
      end
      U_REM_W2: begin
        nx_we        = 1'b1;
        nx_waddr     = t1_q;
        nx_wdata     = t2_q;
        cnt_d        = cnt_q - CNT_W'(1);
        nodes_used_d = nodes_used_q - CNT_W'(1);
        case (op_q)
          OP_TRIM: begin
            cur_d  = t1_q;
            edge_d = EDGE_NONE;
          end
          OP_REMOVE: begin
            cur_d = t2_q;
            if (t2_q == h_w) edge_d = EDGE_BEYOND;
          end
          default: cur_d = t2_q;
        endcase
      end
      U_RELEASE, U_CAT_REL: begin
        slot_top_d   = rel_w;
        slots_used_d = slots_used_q - SLOT_AW'(1);
      end
      U_CAT_RD: begin
        nx_raddr = h2_w;
        pv_raddr = h2_w;
      end
      U_CAT_W1: begin
        nx_we    = 1'b1;
        nx_waddr = cur_q;
        nx_wdata = nx_rdata;
        pv_we    = 1'b1;
        pv_waddr = nx_rdata;
        pv_wdata = cur_q;
        t1_d     = pv_rdata;
      end
      U_CAT_W2: begin
        nx_we        = 1'b1;
        nx_waddr     = t1_q;
        nx_wdata     = h_w;
        pv_we        = 1'b1;
        pv_waddr     = h_w;
        pv_wdata     = t1_q;
        cur_d        = t1_q;
        cnt_d        = cnt_q + cnt2_q;
        slot_top_d   = rel_w;
        slots_used_d = slots_used_q - SLOT_AW'(1);
      end
      default: begin
      end
    endcase
  end

  // control and bookkeeping registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_top_q   <= '0;
      slots_used_q <= '0;
      node_top_q   <= '0;
      nodes_used_q <= '0;
      init_q       <= '0;
      done_q       <= 1'b0;
      wb_q         <= 1'b0;
      in_use_q     <= '0;
      for (int i = 0; i < LIST_SLOTS; i++) begin
        edge_mark_q[i] <= EDGE_NONE;
        items_q[i]     <= '0;
        free_next_q[i] <= (i + 1 < USABLE_SLOTS) ? SLOT_AW'(i + 1) : '0;
      end
    end else begin
      slot_top_q   <= slot_top_d;
      slots_used_q <= slots_used_d;
      node_top_q   <= node_top_d;
      nodes_used_q <= nodes_used_d;
      init_q       <= init_d;
      done_q       <= (cmd_i == U_DONE);
      wb_q         <= wb_d;
      // hand out a slot
      if (create_en_w) begin
        in_use_q[slot_top_q]    <= 1'b1;
        edge_mark_q[slot_top_q] <= EDGE_NONE;
        items_q[slot_top_q]     <= '0;
      end
      // push a slot back on the free stack
      if (rel_en_w) begin
        in_use_q[rel_w]    <= 1'b0;
        edge_mark_q[rel_w] <= EDGE_NONE;
        items_q[rel_w]     <= '0;
        free_next_q[rel_w] <= slot_top_q;
      end
      // write back the list state
      if (cmd_i == U_DONE && wb_q) begin
        edge_mark_q[s_q] <= edge_q;
        items_q[s_q]     <= cnt_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q <= op_d; s_q <= s_d; s2_q <= s2_d; it_q <= it_d;
    cur_q <= cur_d; t1_q <= t1_d; t2_q <= t2_d; n_q <= n_d;
    edge_q <= edge_d; cnt_q <= cnt_d; cnt2_q <= cnt2_d;
    status_q <= status_d; item_q <= item_d; valid_q <= valid_d; new_q <= new_d;
    if (create_en_w) begin
      cursor_q[slot_top_q] <= hc_w;
    end
    if (cmd_i == U_DONE && wb_q) begin
      cursor_q[s_q] <= cur_q;
    end
    if (cmd_i == U_DONE) begin
      res_q.status     <= status_q;
      res_q.item_out   <= item_q;
      res_q.item_valid <= valid_q;
      res_q.count_out  <= wb_q ? cnt_q : '0;
      res_q.new_list   <= new_q;
    end
  end

  assign res_o  = res_q;
  assign done_o = done_q;

  a_nodes_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nodes_used_q <= CNT_W'(NODE_COUNT))
    else $error("node use count beyond pool size");

  a_slots_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(in_use_q) == int'(slots_used_q))
    else $error("slot use count disagrees with in-use bits");

  a_unused_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_q.status == STAT_NOT_USED) |-> (res_q.count_out == '0))
    else $error("count reported for a list not in use");

endmodule
`default_nettype wire
